// ===== rtl/krlc_pkg.sv =====
// shared types and constants for the key report latency checker
`timescale 1ns / 1ps

package krlc_pkg;

    // report storage size
    localparam int REPORT_BYTES = 128;
    localparam int IDX_W = $clog2(REPORT_BYTES);
    localparam int POS_W = $clog2(REPORT_BYTES + 1);

    // operation codes
    localparam logic [2:0] OP_BYTE    = 3'd0;
    localparam logic [2:0] OP_START   = 3'd1;
    localparam logic [2:0] OP_CLICK   = 3'd2;
    localparam logic [2:0] OP_LEARN   = 3'd3;
    localparam logic [2:0] OP_RESTART = 3'd4;
    localparam logic [2:0] OP_DETACH  = 3'd5;

    // error codes
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
    localparam logic [1:0] ERR_NOT_READY  = 2'd2;
    localparam logic [1:0] ERR_DETACHED   = 2'd3;

    // text characters
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    localparam logic [15:0] BATCH_RESET = 16'd1000;

    // input item
    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  report_byte;
        logic        report_last;
        logic [31:0] timestamp_us;
    } t_in;

    // result item
    typedef struct packed {
        logic        kind;
        logic [7:0]  text_char;
        logic        last;
        logic        button_level;
        logic        batch_done;
        logic [1:0]  error_code;
        logic [31:0] max_latency;
        logic [15:0] measured_count;
    } t_out;

    // classified command from front to back
    typedef struct packed {
        logic        is_byte;
        logic        is_ctrl;
        logic [2:0]  op;
        logic [7:0]  data;
        logic        last;
        logic [31:0] ts;
    } t_cmd;

endpackage

// ===== rtl/krlc_front.sv =====
// front end: accepts and classifies input items into a two-entry queue
`timescale 1ns / 1ps

module krlc_front import krlc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_in  i_in,
    output logic o_full,
    output logic o_cmd_valid,
    output t_cmd o_cmd,
    input  logic i_cmd_ready
);

    logic [1:0] r_cnt;
    t_cmd       r_q0;
    t_cmd       r_q1;
    t_cmd       w_new;
    logic       w_push;
    logic       w_pop;

    // classify the incoming item
    always_comb begin
        w_new.is_byte = (i_in.operation == OP_BYTE);
        w_new.is_ctrl = (i_in.operation != OP_BYTE) && (i_in.operation <= OP_DETACH);
        w_new.op      = i_in.operation;
        w_new.data    = i_in.report_byte;
        w_new.last    = i_in.report_last;
        w_new.ts      = i_in.timestamp_us;
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q0;
    assign w_push      = i_push && !o_full;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    // queue occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (w_push && !w_pop) begin
            r_cnt <= r_cnt + 2'd1;
        end else if (w_pop && !w_push) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // queue entries, head in r_q0
    always_ff @(posedge i_clk) begin
        if (w_push && w_pop) begin
            if (r_cnt == 2'd1) begin
                r_q0 <= w_new;
            end else begin
                r_q0 <= r_q1;
                r_q1 <= w_new;
            end
        end else if (w_push) begin
            if (r_cnt == 2'd0) begin
                r_q0 <= w_new;
            end else begin
                r_q1 <= w_new;
            end
        end else if (w_pop) begin
            r_q0 <= r_q1;
        end
    end

endmodule

// ===== rtl/krlc_back.sv =====
// back end: report matching, reference storage, latency text and status
`timescale 1ns / 1ps

module krlc_back import krlc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_cmd_ready,
    output logic        o_res_valid,
    output t_out        o_res,
    input  logic        i_res_ready
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_CMP  = 9'b000000010,
        S_FIN  = 9'b000000100,
        S_CPR  = 9'b000001000,
        S_CPW  = 9'b000010000,
        S_CONV = 9'b000100000,
        S_DIG  = 9'b001000000,
        S_NL   = 9'b010000000,
        S_STAT = 9'b100000000
    } t_state;

    t_state             r_state;
    t_cmd               r_cmd;
    logic [POS_W-1:0]   r_pos;
    logic [POS_W-1:0]   r_len;
    logic               r_pm;
    logic               r_rm;
    logic               r_pseen;
    logic               r_rseen;
    logic               r_learn;
    logic               r_button;
    logic [31:0]        r_max;
    logic [15:0]        r_clicks;
    logic [15:0]        r_batch;
    logic [1:0]         r_err;
    logic               r_bdone;
    logic               r_cmp_en;
    logic [IDX_W-1:0]   r_cp_idx;
    logic [POS_W-1:0]   r_cp_cnt;
    logic               r_cp_to_press;
    logic [31:0]        r_bin;
    logic [39:0]        r_bcd;
    logic [4:0]         r_conv_cnt;
    logic [3:0]         r_dig;

    logic [7:0]         r_press_mem [REPORT_BYTES];
    logic [7:0]         r_rel_mem   [REPORT_BYTES];
    logic [7:0]         r_stage_mem [REPORT_BYTES];
    logic [7:0]         r_press_q;
    logic [7:0]         r_rel_q;
    logic [7:0]         r_stage_q;

    logic               w_take;
    logic               w_in_range;
    logic [IDX_W-1:0]   w_rd_addr;
    logic               w_stage_we;
    logic               w_press_we;
    logic               w_rel_we;
    logic               w_long;
    logic               w_take_press;
    logic               w_take_rel;
    logic [39:0]        n_bcd;
    logic [3:0]         w_first_dig;
    logic [3:0]         w_cur_dig;

    assign o_cmd_ready = (r_state == S_IDLE);
    assign w_take      = i_cmd_valid && o_cmd_ready;
    assign w_in_range  = (r_pos < POS_W'(REPORT_BYTES));

    // memory addressing: report position while receiving, copy index otherwise
    assign w_rd_addr  = (r_state == S_IDLE) ? r_pos[IDX_W-1:0] : r_cp_idx;
    assign w_stage_we = w_take && i_cmd.is_byte && w_in_range;
    assign w_press_we = (r_state == S_CPW) && r_cp_to_press;
    assign w_rel_we   = (r_state == S_CPW) && !r_cp_to_press;

    // staging buffer for the report in progress
    always_ff @(posedge i_clk) begin
        if (w_stage_we) begin
            r_stage_mem[r_pos[IDX_W-1:0]] <= i_cmd.data;
        end
        r_stage_q <= r_stage_mem[w_rd_addr];
    end

    // pressed reference
    always_ff @(posedge i_clk) begin
        if (w_press_we) begin
            r_press_mem[r_cp_idx] <= r_stage_q;
        end
        r_press_q <= r_press_mem[w_rd_addr];
    end

    // released reference
    always_ff @(posedge i_clk) begin
        if (w_rel_we) begin
            r_rel_mem[r_cp_idx] <= r_stage_q;
        end
        r_rel_q <= r_rel_mem[w_rd_addr];
    end

    // report end classification
    assign w_long       = (r_pos >= r_len);
    assign w_take_press = r_pm && w_long && !r_button && !r_rseen && !r_pseen;
    assign w_take_rel   = r_rm && w_long && r_button && r_pseen && !r_rseen;

    // one double dabble step and leading digit search
    always_comb begin
        logic [39:0] adj;
        adj = r_bcd;
        for (int d = 0; d < 10; d++) begin
            if (adj[d*4 +: 4] >= 4'd5) begin
                adj[d*4 +: 4] = adj[d*4 +: 4] + 4'd3;
            end
        end
        n_bcd = {adj[38:0], r_bin[31]};
        w_first_dig = 4'd0;
        for (int d = 1; d < 10; d++) begin
            if (n_bcd[d*4 +: 4] != 4'd0) begin
                w_first_dig = 4'(d);
            end
        end
    end

    assign w_cur_dig = r_bcd[r_dig*4 +: 4];

    // result assembly
    always_comb begin
        o_res_valid          = (r_state == S_STAT) || (r_state == S_DIG) || (r_state == S_NL);
        o_res.kind           = (r_state == S_DIG) || (r_state == S_NL);
        o_res.text_char      = (r_state == S_DIG) ? (CH_ZERO + {4'd0, w_cur_dig}) :
                               (r_state == S_NL)  ? CH_NEWLINE : 8'd0;
        o_res.last           = (r_state != S_DIG);
        o_res.button_level   = r_button;
        o_res.batch_done     = (r_state == S_STAT) ? r_bdone : 1'b0;
        o_res.error_code     = (r_state == S_STAT) ? r_err : ERR_NONE;
        o_res.max_latency    = r_max;
        o_res.measured_count = r_clicks;
    end

    // batch count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_batch <= BATCH_RESET;
        end else if (i_cfg_we) begin
            r_batch <= i_cfg_data;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pos    <= '0;
            r_len    <= '0;
            r_pm     <= 1'b1;
            r_rm     <= 1'b1;
            r_pseen  <= 1'b0;
            r_rseen  <= 1'b0;
            r_learn  <= 1'b0;
            r_button <= 1'b1;
            r_max    <= 32'd0;
            r_clicks <= 16'd0;
            r_err    <= ERR_NONE;
            r_bdone  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        r_cmd   <= i_cmd;
                        r_bdone <= 1'b0;
                        if (i_cmd.is_byte) begin
                            r_err    <= ERR_NONE;
                            r_cmp_en <= w_in_range && (r_pos < r_len);
                            if (w_in_range) begin
                                r_pos <= r_pos + POS_W'(1);
                            end
                            r_state <= S_CMP;
                        end else begin
                            if (i_cmd.is_ctrl) begin
                                r_pos <= '0;
                                r_pm  <= 1'b1;
                                r_rm  <= 1'b1;
                            end
                            case (i_cmd.op)
                                OP_START: begin
                                    r_err    <= ERR_NONE;
                                    r_pseen  <= 1'b0;
                                    r_rseen  <= 1'b0;
                                    r_button <= 1'b0;
                                end
                                OP_CLICK: begin
                                    if (!r_pseen || !r_rseen || !r_button) begin
                                        r_err <= ERR_NOT_READY;
                                    end else begin
                                        r_err    <= ERR_NONE;
                                        r_pseen  <= 1'b0;
                                        r_rseen  <= 1'b0;
                                        r_button <= 1'b0;
                                    end
                                end
                                OP_LEARN: begin
                                    r_err   <= ERR_NONE;
                                    r_learn <= 1'b1;
                                    r_pseen <= 1'b0;
                                    r_rseen <= 1'b0;
                                end
                                OP_RESTART: begin
                                    r_err    <= ERR_NONE;
                                    r_clicks <= 16'd0;
                                end
                                OP_DETACH:  r_err <= ERR_DETACHED;
                                default:    r_err <= ERR_NONE;
                            endcase
                            r_state <= S_STAT;
                        end
                    end
                end
                S_CMP: begin
                    if (r_cmp_en) begin
                        if (r_press_q != r_cmd.data) r_pm <= 1'b0;
                        if (r_rel_q != r_cmd.data)   r_rm <= 1'b0;
                    end
                    r_state <= r_cmd.last ? S_FIN : S_STAT;
                end
                S_FIN: begin
                    r_pos    <= '0;
                    r_pm     <= 1'b1;
                    r_rm     <= 1'b1;
                    r_cp_cnt <= r_pos;
                    r_cp_idx <= '0;
                    if (r_learn) begin
                        if (!r_pseen) begin
                            r_len         <= r_pos;
                            r_pseen       <= 1'b1;
                            r_cp_to_press <= 1'b1;
                            r_state       <= (r_pos == '0) ? S_STAT : S_CPR;
                        end else if (!r_rseen) begin
                            r_rseen       <= 1'b1;
                            r_learn       <= 1'b0;
                            r_cp_to_press <= 1'b0;
                            r_state       <= (r_pos == '0) ? S_STAT : S_CPR;
                        end else begin
                            r_state <= S_STAT;
                        end
                    end else if (w_take_press) begin
                        if (r_cmd.ts > r_max) r_max <= r_cmd.ts;
                        if (r_clicks != 16'hFFFF) r_clicks <= r_clicks + 16'd1;
                        r_pseen    <= 1'b1;
                        r_button   <= 1'b1;
                        r_bin      <= r_cmd.ts;
                        r_bcd      <= 40'd0;
                        r_conv_cnt <= 5'd0;
                        r_state    <= S_CONV;
                    end else if (w_take_rel) begin
                        r_rseen <= 1'b1;
                        r_bdone <= (r_clicks >= r_batch);
                        r_state <= S_STAT;
                    end else begin
                        r_err         <= ERR_UNEXPECTED;
                        r_cp_to_press <= 1'b0;
                        r_state       <= (r_pos == '0) ? S_STAT : S_CPR;
                    end
                end
                S_CPR: begin
                    r_state <= S_CPW;
                end
                S_CPW: begin
                    if (({1'b0, r_cp_idx} + POS_W'(1)) == r_cp_cnt) begin
                        r_state <= S_STAT;
                    end else begin
                        r_cp_idx <= r_cp_idx + IDX_W'(1);
                        r_state  <= S_CPR;
                    end
                end
                S_CONV: begin
                    r_bcd      <= n_bcd;
                    r_bin      <= {r_bin[30:0], 1'b0};
                    r_conv_cnt <= r_conv_cnt + 5'd1;
                    if (r_conv_cnt == 5'd31) begin
                        r_dig   <= w_first_dig;
                        r_state <= S_DIG;
                    end
                end
                S_DIG: begin
                    if (i_res_ready) begin
                        if (r_dig == 4'd0) begin
                            r_state <= S_NL;
                        end else begin
                            r_dig <= r_dig - 4'd1;
                        end
                    end
                end
                S_NL: begin
                    if (i_res_ready) r_state <= S_IDLE;
                end
                S_STAT: begin
                    if (i_res_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // position and learned length stay within the buffer
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(REPORT_BYTES)) else $error("report position out of range");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= POS_W'(REPORT_BYTES)) else $error("reference length out of range");

    // a measured press releases the button and marks the press seen
    a_press_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && !r_learn && w_take_press) |=> (r_button && r_pseen))
        else $error("measured press did not release the button");

    // the copy never runs past the staged count
    a_copy_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CPW) |-> ({1'b0, r_cp_idx} < r_cp_cnt))
        else $error("reference copy overran the report");

endmodule

// ===== rtl/krlc_outq.sv =====
// result queue: two-entry buffer between back end and result port
`timescale 1ns / 1ps

module krlc_outq import krlc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_out i_res,
    output logic o_ready,
    output logic o_empty,
    output t_out o_res,
    input  logic i_pop
);

    logic [1:0] r_cnt;
    t_out       r_q0;
    t_out       r_q1;
    logic       w_push;
    logic       w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_res   = r_q0;
    assign w_push  = i_valid && o_ready;
    assign w_pop   = i_pop && !o_empty;

    // occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (w_push && !w_pop) begin
            r_cnt <= r_cnt + 2'd1;
        end else if (w_pop && !w_push) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // entries, oldest in r_q0
    always_ff @(posedge i_clk) begin
        if (w_push && w_pop) begin
            if (r_cnt == 2'd1) begin
                r_q0 <= i_res;
            end else begin
                r_q0 <= r_q1;
                r_q1 <= i_res;
            end
        end else if (w_push) begin
            if (r_cnt == 2'd0) begin
                r_q0 <= i_res;
            end else begin
                r_q1 <= i_res;
            end
        end else if (w_pop) begin
            r_q0 <= r_q1;
        end
    end

endmodule

// ===== rtl/key_report_latency_checker.sv =====
// top level of the key report latency checker
//
// Input items go in through push/full: an item transfers on a clock edge
// with push high and full low. A two-entry queue sits in front of the
// back end. Results come out through empty/pop: the oldest result shows on
// o_res while empty is low and transfers on an edge with pop high.
// The user writes batch_count via i_cfg_we/i_cfg_data only while the block
// idles; the block does not enforce it. In the back end a control operation
// gives a status result; a report byte is compared, and a final byte also
// copies each stored byte when the report goes into a reference; a measured
// press runs a 32-step binary to decimal conversion, then emits digits and
// a newline. Reference bytes sit in single-port memories read one address a
// cycle. Reset clears all control state, drops both queues, leaves the
// button released and batch_count at 1000; reference memories are not
// cleared. When pop stays low the result queue fills, the back end holds
// its current result, then the input queue fills and full goes high.
`timescale 1ns / 1ps

module key_report_latency_checker import krlc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  t_in         i_in,
    output logic        full,
    output logic        empty,
    output t_out        o_res,
    input  logic        pop,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data
);

    logic cmd_valid;
    logic cmd_ready;
    t_cmd cmd;
    logic res_valid;
    logic res_ready;
    t_out res;

    // front end and command queue
    krlc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_in        (i_in),
        .o_full      (full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_ready (cmd_ready)
    );

    // matching and text generation
    krlc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_ready (cmd_ready),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    // result queue
    krlc_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_res   (res),
        .o_ready (res_ready),
        .o_empty (empty),
        .o_res   (o_res),
        .i_pop   (pop)
    );

endmodule

// ===== test/tb_top.sv =====
// testbench for the key report latency checker: directed table, then random sequences
`timescale 1ns / 1ps

module tb_top;
    import krlc_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    t_in         i_in;
    logic        full;
    logic        empty;
    t_out        o_res;
    logic        pop;
    logic        i_cfg_we;
    logic [15:0] i_cfg_data;

    key_report_latency_checker dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .i_in       (i_in),
        .full       (full),
        .empty      (empty),
        .o_res      (o_res),
        .pop        (pop),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // predictor state
    logic [7:0]  prs_ref [REPORT_BYTES];
    logic [7:0]  rel_ref [REPORT_BYTES];
    logic [7:0]  staging [REPORT_BYTES];
    int          ref_len;
    int          pos;
    logic        prs_ok, rel_ok, prs_seen, rel_seen, learning, btn_up;
    logic [31:0] max_lat;
    logic [15:0] clicks;
    logic [15:0] batch_limit;

    t_out        expected_results[$];
    int          errors;
    int          shown;
    longint      cycles;
    logic        hold_off;
    logic        long_pending;

    // directed rows
    typedef struct {
        t_in  item;
        logic has_exp;
        t_out exp_res;
    } t_row;
    t_row rows[$];

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // cycle limit
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 2000000) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    function automatic t_out status(logic [1:0] err, logic bd);
        t_out r;
        r.kind = 0;
        r.text_char = 8'd0;
        r.last = 1;
        r.button_level = btn_up;
        r.batch_done = bd;
        r.error_code = err;
        r.max_latency = max_lat;
        r.measured_count = clicks;
        return r;
    endfunction

    function automatic void clear_partial();
        pos = 0;
        prs_ok = 1;
        rel_ok = 1;
    endfunction

    // compute results for one accepted item
    task automatic predict_item(input t_in it);
        logic [1:0]  err;
        logic        bd, pm, rm;
        int          cnt, nd;
        logic [7:0]  dg[10];
        logic [31:0] v;
        t_out        r;
        err = ERR_NONE;
        bd = 0;
        if (it.operation != OP_BYTE) begin
            if (it.operation <= OP_DETACH) clear_partial();
            case (it.operation)
                OP_START: begin
                    prs_seen = 0; rel_seen = 0; btn_up = 0;
                end
                OP_CLICK: begin
                    if (!prs_seen || !rel_seen || !btn_up) err = ERR_NOT_READY;
                    else begin
                        prs_seen = 0; rel_seen = 0; btn_up = 0;
                    end
                end
                OP_LEARN: begin
                    learning = 1; prs_seen = 0; rel_seen = 0;
                end
                OP_RESTART: clicks = 0;
                OP_DETACH: err = ERR_DETACHED;
                default: ;
            endcase
            expected_results.push_back(status(err, 0));
            return;
        end
        if (pos < REPORT_BYTES) begin
            staging[pos] = it.report_byte;
            if (pos < ref_len) begin
                if (prs_ref[pos] != it.report_byte) prs_ok = 0;
                if (rel_ref[pos] != it.report_byte) rel_ok = 0;
            end
            pos++;
        end
        if (!it.report_last) begin
            expected_results.push_back(status(ERR_NONE, 0));
            return;
        end
        cnt = pos;
        pm = prs_ok && cnt >= ref_len;
        rm = rel_ok && cnt >= ref_len;
        clear_partial();
        if (learning) begin
            if (!prs_seen) begin
                for (int i = 0; i < cnt; i++) prs_ref[i] = staging[i];
                ref_len = cnt;
                prs_seen = 1;
            end else if (!rel_seen) begin
                for (int i = 0; i < cnt; i++) rel_ref[i] = staging[i];
                rel_seen = 1;
                learning = 0;
            end
        end else if (pm && !btn_up && !rel_seen && !prs_seen) begin
            if (it.timestamp_us > max_lat) max_lat = it.timestamp_us;
            if (clicks != 16'hFFFF) clicks++;
            prs_seen = 1;
            btn_up = 1;
            v = it.timestamp_us;
            nd = 0;
            do begin
                dg[nd] = CH_ZERO + 8'(v % 10);
                nd++;
                v = v / 10;
            end while (v != 0);
            for (int i = nd - 1; i >= 0; i--) begin
                r = status(ERR_NONE, 0);
                r.kind = 1; r.text_char = dg[i]; r.last = 0;
                expected_results.push_back(r);
            end
            r = status(ERR_NONE, 0);
            r.kind = 1; r.text_char = CH_NEWLINE;
            expected_results.push_back(r);
            return;
        end else if (rm && btn_up && prs_seen && !rel_seen) begin
            rel_seen = 1;
            if (clicks >= batch_limit) bd = 1;
        end else begin
            for (int i = 0; i < cnt; i++) rel_ref[i] = staging[i];
            err = ERR_UNEXPECTED;
        end
        expected_results.push_back(status(err, bd));
    endtask

    // result side: random pop gaps, one long hold-off counted here
    initial begin
        int gap;
        logic held;
        pop = 0;
        errors = 0;
        shown = 0;
        held = 0;
        @(posedge i_rst_n);
        forever begin
            gap = $urandom_range(0, 4);
            if ($urandom_range(0, 3) == 0) gap = 0;
            repeat (gap) begin
                @(posedge i_clk);
                pop <= 0;
            end
            if (hold_off && !held) begin
                repeat (300) begin
                    @(posedge i_clk);
                    pop <= 0;
                end
                held = 1;
            end
            @(posedge i_clk);
            pop <= 1;
            do @(posedge i_clk); while (empty);
            // transfer happens at this edge
            if (expected_results.size() == 0) begin
                errors++;
                if (shown < 10) begin
                    shown++;
                    $display("unexpected result %p", o_res);
                end
            end else begin
                t_out e;
                e = expected_results.pop_front();
                if (o_res !== e) begin
                    errors++;
                    if (shown < 10) begin
                        shown++;
                        $display("mismatch exp %p got %p", e, o_res);
                    end
                end
            end
            pop <= 0;
        end
    end

    // send one item, predict at the transfer
    task automatic send(input t_in it, input logic no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 4);
        repeat (gap) begin
            @(posedge i_clk);
            push <= 0;
        end
        @(posedge i_clk);
        push <= 1;
        i_in <= it;
        do @(posedge i_clk); while (full);
        predict_item(it);
        push <= 0;
    endtask

    task automatic wait_idle();
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic set_batch(input logic [15:0] v);
        wait_idle();
        @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
        batch_limit = v;
    endtask

    function automatic t_in mk(logic [2:0] op, logic [7:0] b, logic l, logic [31:0] ts);
        t_in it;
        it.operation = op; it.report_byte = b; it.report_last = l; it.timestamp_us = ts;
        return it;
    endfunction

    // random report: pressed, released or noise, sometimes of a random length, once long
    task automatic send_report(input int kind_sel, input logic [31:0] ts);
        int n;
        logic [7:0] b;
        n = ref_len;
        if ($urandom_range(0, 9) == 0) n = $urandom_range(1, 10);
        if (long_pending && kind_sel == 1) begin
            n = REPORT_BYTES + 2;
            long_pending = 0;
        end
        if (n == 0) n = 1;
        for (int i = 0; i < n; i++) begin
            if (i < ref_len && kind_sel == 0) b = prs_ref[i];
            else if (i < ref_len && kind_sel == 1) b = rel_ref[i];
            else b = 8'($urandom);
            if (kind_sel == 2 && $urandom_range(0, 3) == 0) b = 8'($urandom);
            send(mk(OP_BYTE, b, i == n - 1, ts), 0);
        end
    endtask

    initial begin
        logic [31:0] ts;
        push = 0;
        i_in = '0;
        i_cfg_we = 0;
        i_cfg_data = 16'd0;
        i_rst_n = 0;
        hold_off = 0;
        long_pending = 1;
        for (int i = 0; i < REPORT_BYTES; i++) begin
            prs_ref[i] = 0; rel_ref[i] = 0; staging[i] = 0;
        end
        ref_len = 0;
        clear_partial();
        prs_seen = 0; rel_seen = 0; learning = 0; btn_up = 1;
        max_lat = 0; clicks = 0; batch_limit = BATCH_RESET;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: status after reset, learn, press/release with extremes
        rows.push_back('{mk(OP_DETACH, 8'hFF, 1, 32'hFFFFFFFF), 1,
            '{0, 8'd0, 1, 1, 0, ERR_DETACHED, 32'd0, 16'd0}});
        rows.push_back('{mk(OP_CLICK, 8'h00, 0, 0), 1,
            '{0, 8'd0, 1, 1, 0, ERR_NOT_READY, 32'd0, 16'd0}});
        rows.push_back('{mk(3'd6, 8'h00, 0, 0), 0, '0});
        rows.push_back('{mk(3'd7, 8'hAA, 1, 0), 0, '0});
        rows.push_back('{mk(OP_LEARN, 0, 0, 0), 0, '0});
        rows.push_back('{mk(OP_BYTE, 8'h00, 0, 0), 0, '0});
        rows.push_back('{mk(OP_BYTE, 8'hFF, 0, 0), 0, '0});
        rows.push_back('{mk(OP_BYTE, 8'h04, 1, 0), 0, '0});
        rows.push_back('{mk(OP_BYTE, 8'h00, 0, 0), 0, '0});
        rows.push_back('{mk(OP_BYTE, 8'h00, 0, 0), 0, '0});
        rows.push_back('{mk(OP_BYTE, 8'h00, 1, 0), 0, '0});
        rows.push_back('{mk(OP_BYTE, 8'h55, 1, 0), 0, '0});
        rows.push_back('{mk(OP_START, 0, 0, 0), 0, '0});
        rows.push_back('{mk(OP_BYTE, 8'h00, 1, 0), 0, '0});
        rows.push_back('{mk(OP_START, 0, 0, 0), 0, '0});
        rows.push_back('{mk(OP_BYTE, 8'h00, 0, 0), 0, '0});
        rows.push_back('{mk(OP_BYTE, 8'hFF, 0, 0), 0, '0});
        rows.push_back('{mk(OP_BYTE, 8'h04, 1, 32'd0), 0, '0});
        rows.push_back('{mk(OP_BYTE, 8'h00, 0, 0), 0, '0});
        rows.push_back('{mk(OP_BYTE, 8'h00, 0, 0), 0, '0});
        rows.push_back('{mk(OP_BYTE, 8'h00, 1, 0), 0, '0});
        rows.push_back('{mk(OP_CLICK, 0, 0, 0), 0, '0});
        rows.push_back('{mk(OP_BYTE, 8'h00, 0, 0), 0, '0});
        rows.push_back('{mk(OP_BYTE, 8'hFF, 0, 0), 0, '0});
        rows.push_back('{mk(OP_BYTE, 8'h04, 1, 32'hFFFFFFFF), 0, '0});
        foreach (rows[i]) begin
            if (rows[i].has_exp) begin
                // typed expectation replaces the predicted one
                send(rows[i].item, 0);
                void'(expected_results.pop_back());
                expected_results.push_back(rows[i].exp_res);
            end else send(rows[i].item, 0);
        end
        rows.delete();

        // random part across batch settings, extremes included
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: set_batch(16'd1);
                1: set_batch(16'hFFFF);
                2: set_batch(16'd3);
                default: set_batch(16'($urandom_range(1, 8)));
            endcase
            if (ph == 2) begin
                // relearn with a fresh pair, both of one random length
                int n;
                n = $urandom_range(1, 6);
                send(mk(OP_LEARN, 0, 0, 0), 0);
                for (int r = 0; r < 2; r++) begin
                    for (int i = 0; i < n; i++)
                        send(mk(OP_BYTE, 8'($urandom), i == n - 1, 0), 0);
                end
            end
            if (ph == 1) hold_off = 1;
            send(mk(OP_START, 0, 0, 0), 0);
            for (int c = 0; c < 2; c++) begin
                ts = $urandom;
                if ($urandom_range(0, 5) == 0) ts = $urandom_range(0, 99);
                send_report($urandom_range(0, 9) == 0 ? 2 : 0, ts);
                send_report($urandom_range(0, 9) == 0 ? 2 : 1, $urandom);
                case ($urandom_range(0, 11))
                    0: send(mk(OP_RESTART, 0, 0, 0), 0);
                    1: send(mk(OP_DETACH, 8'($urandom), 1'($urandom), $urandom), 0);
                    2: send(mk(3'($urandom_range(6, 7)), 8'($urandom), 1'($urandom),
                               $urandom), 0);
                    3: send(mk(OP_START, 0, 0, 0), 0);
                    default: ;
                endcase
                send(mk(OP_CLICK, 0, 0, 0), 0);
            end
        end
        wait_idle();
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
